// ===== rtl/ccnd_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ccnd_pkg
// Types and constants shared by the crop / downscale / quantize block.
// ----------------------------------------------------------------------------
package ccnd_pkg;

    localparam int CFG_DATA_W  = 26;
    localparam int CFG_IDX_W   = 3;
    localparam int DIM_W       = 10;
    localparam int SCALE_W     = 26;
    localparam int PIX_W       = 24;
    localparam int OUT_COORD_W = 10;
    localparam int FRAC_BITS   = 16;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_SRC_WIDTH,
        REG_SRC_HEIGHT,
        REG_DST_WIDTH,
        REG_DST_HEIGHT,
        REG_SCALE_X,
        REG_SCALE_Y,
        REG_INPUT_FORMAT
    } cfg_reg_t;

    typedef enum logic {
        FMT_RGB888,
        FMT_RGB565
    } pix_fmt_t;

    localparam logic [DIM_W-1:0]   RST_SRC_WIDTH  = 10'd320;
    localparam logic [DIM_W-1:0]   RST_SRC_HEIGHT = 10'd240;
    localparam logic [DIM_W-1:0]   RST_DST_WIDTH  = 10'd224;
    localparam logic [DIM_W-1:0]   RST_DST_HEIGHT = 10'd224;
    localparam logic [SCALE_W-1:0] RST_SCALE      = 26'd70217;

    localparam logic [7:0] QUANT_FLIP = 8'h80;

    typedef struct packed {
        logic              start_of_frame;
        logic [PIX_W-1:0]  pixel_word;
    } in_beat_t;

    typedef struct packed {
        logic signed [7:0] red_q;
        logic signed [7:0] green_q;
        logic signed [7:0] blue_q;
        logic [15:0]       display_rgb565;
    } pix_q_t;

    typedef struct packed {
        logic signed [7:0]       red_q;
        logic signed [7:0]       green_q;
        logic signed [7:0]       blue_q;
        logic [15:0]             display_rgb565;
        logic [OUT_COORD_W-1:0]  out_col;
        logic [OUT_COORD_W-1:0]  out_row;
        logic                    frame_done;
    } out_beat_t;

endpackage

// ===== rtl/ccnd_pixel_fmt.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ccnd_pixel_fmt
// Unpacks RGB888 or RGB565 into bytes, flips to int8 and repacks RGB565.
// ----------------------------------------------------------------------------
module ccnd_pixel_fmt (
    input  logic [ccnd_pkg::PIX_W-1:0] pixel_word,
    input  ccnd_pkg::pix_fmt_t         fmt,
    output ccnd_pkg::pix_q_t           pix
);

    logic [7:0] r;
    logic [7:0] g;
    logic [7:0] b;

    always_comb
    begin
        if (fmt == ccnd_pkg::FMT_RGB565)
        begin
            r = {pixel_word[15:11], 3'b000};
            g = {pixel_word[10:5], 2'b00};
            b = {pixel_word[4:0], 3'b000};
        end
        else
        begin
            r = pixel_word[23:16];
            g = pixel_word[15:8];
            b = pixel_word[7:0];
        end
    end

    always_comb
    begin
        pix.red_q          = signed'(r ^ ccnd_pkg::QUANT_FLIP);
        pix.green_q        = signed'(g ^ ccnd_pkg::QUANT_FLIP);
        pix.blue_q         = signed'(b ^ ccnd_pkg::QUANT_FLIP);
        pix.display_rgb565 = {r[7:3], g[7:2], b[7:3]};
    end

endmodule

// ===== rtl/center_crop_nn_downscale_quant.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// center_crop_nn_downscale_quant
// Center-crops the largest square of a raster pixel stream, downsamples it
// by nearest neighbor and emits int8 channels plus an RGB565 display word.
// ----------------------------------------------------------------------------
// Usage:
//   in_valid/in_ready carry one source pixel per beat in raster order;
//   start_of_frame on the first pixel restarts all position tracking.
//   out_valid/out_ready carry one beat per kept pixel, with its output
//   column/row and frame_done on the last pixel of the output frame.
//   Source pixels outside the sampled grid produce no output beat.
//   cfg_write/cfg_index/cfg_data write the geometry, Q16 steps and input
//   format; write only while the block is idle.
// Timing:
//   One pixel per cycle sustained while the output is not stalled. A beat
//   accepted into the input register is evaluated there and its result is
//   registered into the output register. The per-pixel position update loop
//   (target add, clamp, compare, Q16 accumulate) sets that rate.
// Reset:
//   Registers return to 320x240 in, 224x224 out, step 70217, RGB888;
//   positions clear and both channels come up empty.
// Backpressure:
//   A stalled output holds its beat; one more input beat is taken into the
//   input register, after which in_ready drops until the output drains.
// ----------------------------------------------------------------------------
module center_crop_nn_downscale_quant #(
    parameter int COORD_BITS = 10
) (
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               in_valid,
    output logic                               in_ready,
    input  ccnd_pkg::in_beat_t                 in_beat,
    output logic                               out_valid,
    input  logic                               out_ready,
    output ccnd_pkg::out_beat_t                out_beat,
    input  logic                               cfg_write,
    input  logic [ccnd_pkg::CFG_IDX_W-1:0]     cfg_index,
    input  logic [ccnd_pkg::CFG_DATA_W-1:0]    cfg_data
);

    localparam int DW    = ccnd_pkg::DIM_W;
    localparam int CB    = COORD_BITS;
    localparam int ACC_W = COORD_BITS + ccnd_pkg::FRAC_BITS;
    localparam int CW    = ((CB > DW) ? CB : DW) + 1;
    localparam int SUM_W = ((ACC_W > ccnd_pkg::SCALE_W) ? ACC_W : ccnd_pkg::SCALE_W) + 1;

    // configuration
    logic [DW-1:0]                    src_width_reg;
    logic [DW-1:0]                    src_height_reg;
    logic [DW-1:0]                    dst_width_reg;
    logic [DW-1:0]                    dst_height_reg;
    logic [ccnd_pkg::SCALE_W-1:0]     scale_x_reg;
    logic [ccnd_pkg::SCALE_W-1:0]     scale_y_reg;
    ccnd_pkg::pix_fmt_t               input_format_reg;

    // derived geometry
    logic [DW-1:0] sw_c, sh_c, crop_c;
    logic [DW-1:0] sw_reg, x0_reg, y0_reg, swm1_reg, shm1_reg;

    // input stage
    logic               s1_valid_reg;
    ccnd_pkg::in_beat_t s1_beat_reg;
    logic               s1_adv;

    // position state
    logic [CB-1:0]    source_col_reg, source_col_next;
    logic [CB-1:0]    source_row_reg, source_row_next;
    logic [CB-1:0]    next_out_col_reg, next_out_col_next;
    logic [CB-1:0]    next_out_row_reg, next_out_row_next;
    logic [ACC_W-1:0] col_accum_reg, col_accum_next;
    logic [ACC_W-1:0] row_accum_reg, row_accum_next;

    logic [CB-1:0]    sc0, sr0, noc0, nor0;
    logic [ACC_W-1:0] cacc0, racc0;
    logic [CW-1:0]    tx_sum, ty_sum, tx, ty;
    logic [CB:0]      noc_inc, nor_inc;
    logic [CB-1:0]    sc_inc;
    logic             keep;
    logic             frame_done_c;
    logic [CW-1:0]    col_wide, row_wide;

    ccnd_pkg::pix_q_t    pix;
    logic                out_valid_reg, out_valid_next;
    ccnd_pkg::out_beat_t out_beat_reg, out_beat_next;

    function automatic logic [ACC_W-1:0] sat_add(
        input logic [ACC_W-1:0]             a,
        input logic [ccnd_pkg::SCALE_W-1:0] b
    );
        logic [SUM_W-1:0] s;
        s = SUM_W'(a) + SUM_W'(b);
        if (s > SUM_W'({ACC_W{1'b1}}))
            return {ACC_W{1'b1}};
        else
            return s[ACC_W-1:0];
    endfunction

    // ---------------- configuration port
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            src_width_reg    <= ccnd_pkg::RST_SRC_WIDTH;
            src_height_reg   <= ccnd_pkg::RST_SRC_HEIGHT;
            dst_width_reg    <= ccnd_pkg::RST_DST_WIDTH;
            dst_height_reg   <= ccnd_pkg::RST_DST_HEIGHT;
            scale_x_reg      <= ccnd_pkg::RST_SCALE;
            scale_y_reg      <= ccnd_pkg::RST_SCALE;
            input_format_reg <= ccnd_pkg::FMT_RGB888;
        end
        else if (cfg_write)
        begin
            case (cfg_index)
                ccnd_pkg::REG_SRC_WIDTH:    src_width_reg    <= cfg_data[DW-1:0];
                ccnd_pkg::REG_SRC_HEIGHT:   src_height_reg   <= cfg_data[DW-1:0];
                ccnd_pkg::REG_DST_WIDTH:    dst_width_reg    <= cfg_data[DW-1:0];
                ccnd_pkg::REG_DST_HEIGHT:   dst_height_reg   <= cfg_data[DW-1:0];
                ccnd_pkg::REG_SCALE_X:      scale_x_reg      <= cfg_data;
                ccnd_pkg::REG_SCALE_Y:      scale_y_reg      <= cfg_data;
                ccnd_pkg::REG_INPUT_FORMAT:
                    input_format_reg <= ccnd_pkg::pix_fmt_t'(cfg_data[0]);
                default: ;
            endcase
        end
    end

    // zero size counts as one; crop offset is half the excess
    always_comb
    begin
        sw_c   = (src_width_reg == '0) ? DW'(1) : src_width_reg;
        sh_c   = (src_height_reg == '0) ? DW'(1) : src_height_reg;
        crop_c = (sw_c < sh_c) ? sw_c : sh_c;
    end

    always_ff @(posedge clk)
    begin
        sw_reg   <= sw_c;
        x0_reg   <= (sw_c - crop_c) >> 1;
        y0_reg   <= (sh_c - crop_c) >> 1;
        swm1_reg <= sw_c - DW'(1);
        shm1_reg <= sh_c - DW'(1);
    end

    // ---------------- input register
    assign s1_adv   = s1_valid_reg && (!out_valid_reg || out_ready);
    assign in_ready = !s1_valid_reg || !out_valid_reg || out_ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            s1_valid_reg <= 1'b0;
        else if (in_ready)
            s1_valid_reg <= in_valid;
    end

    always_ff @(posedge clk)
    begin
        if (in_ready && in_valid)
            s1_beat_reg <= in_beat;
    end

    // ---------------- keep decision and position update
    always_comb
    begin
        if (s1_beat_reg.start_of_frame)
        begin
            sc0   = '0;
            sr0   = '0;
            noc0  = '0;
            nor0  = '0;
            cacc0 = '0;
            racc0 = '0;
        end
        else
        begin
            sc0   = source_col_reg;
            sr0   = source_row_reg;
            noc0  = next_out_col_reg;
            nor0  = next_out_row_reg;
            cacc0 = col_accum_reg;
            racc0 = row_accum_reg;
        end

        tx_sum = CW'(x0_reg) + CW'(cacc0[ACC_W-1:ccnd_pkg::FRAC_BITS]);
        ty_sum = CW'(y0_reg) + CW'(racc0[ACC_W-1:ccnd_pkg::FRAC_BITS]);
        tx     = (tx_sum > CW'(swm1_reg)) ? CW'(swm1_reg) : tx_sum;
        ty     = (ty_sum > CW'(shm1_reg)) ? CW'(shm1_reg) : ty_sum;

        keep = (CW'(nor0) < CW'(dst_height_reg)) && (CW'(noc0) < CW'(dst_width_reg)) &&
               (CW'(sr0) >= ty) && (CW'(sc0) >= tx);

        noc_inc      = (CB+1)'(noc0) + (CB+1)'(1);
        nor_inc      = (CB+1)'(nor0) + (CB+1)'(1);
        frame_done_c = (CW'(noc_inc) == CW'(dst_width_reg)) &&
                       (CW'(nor_inc) == CW'(dst_height_reg));

        next_out_col_next = noc0;
        next_out_row_next = nor0;
        col_accum_next    = cacc0;
        row_accum_next    = racc0;
        if (keep)
        begin
            if (CW'(noc_inc[CB-1:0]) >= CW'(dst_width_reg))
            begin
                next_out_col_next = '0;
                col_accum_next    = '0;
                next_out_row_next = nor_inc[CB-1:0];
                row_accum_next    = sat_add(racc0, scale_y_reg);
            end
            else
            begin
                next_out_col_next = noc_inc[CB-1:0];
                col_accum_next    = sat_add(cacc0, scale_x_reg);
            end
        end

        // column wraps at the source width, row holds at its top value
        sc_inc          = sc0 + CB'(1);
        source_col_next = sc_inc;
        source_row_next = sr0;
        if ((CW'(sc_inc) >= CW'(sw_reg)) || (sc_inc == '0))
        begin
            source_col_next = '0;
            if (sr0 != {CB{1'b1}})
                source_row_next = sr0 + CB'(1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            source_col_reg   <= '0;
            source_row_reg   <= '0;
            next_out_col_reg <= '0;
            next_out_row_reg <= '0;
            col_accum_reg    <= '0;
            row_accum_reg    <= '0;
        end
        else if (s1_adv)
        begin
            source_col_reg   <= source_col_next;
            source_row_reg   <= source_row_next;
            next_out_col_reg <= next_out_col_next;
            next_out_row_reg <= next_out_row_next;
            col_accum_reg    <= col_accum_next;
            row_accum_reg    <= row_accum_next;
        end
    end

    // ---------------- pixel conversion and output register
    ccnd_pixel_fmt u_pixel_fmt (
        .pixel_word (s1_beat_reg.pixel_word),
        .fmt        (input_format_reg),
        .pix        (pix)
    );

    always_comb
    begin
        col_wide                     = CW'(noc0);
        row_wide                     = CW'(nor0);
        out_beat_next.red_q          = pix.red_q;
        out_beat_next.green_q        = pix.green_q;
        out_beat_next.blue_q         = pix.blue_q;
        out_beat_next.display_rgb565 = pix.display_rgb565;
        out_beat_next.out_col        = col_wide[ccnd_pkg::OUT_COORD_W-1:0];
        out_beat_next.out_row        = row_wide[ccnd_pkg::OUT_COORD_W-1:0];
        out_beat_next.frame_done     = frame_done_c;
    end

    always_comb
    begin
        if (s1_adv)
            out_valid_next = keep;
        else
            out_valid_next = out_valid_reg && !out_ready;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else
            out_valid_reg <= out_valid_next;
    end

    always_ff @(posedge clk)
    begin
        if (s1_adv && keep)
            out_beat_reg <= out_beat_next;
    end

    assign out_valid = out_valid_reg;
    assign out_beat  = out_beat_reg;

    // ---------------- assertions
    a_s1_hold: assert property (@(posedge clk) disable iff (!rst_n)
        s1_valid_reg && !s1_adv |=> s1_valid_reg && $stable(s1_beat_reg))
        else $error("input stage lost or changed a stalled beat");

    a_col_range: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg |-> (CW'(out_beat_reg.out_col) < CW'(dst_width_reg)))
        else $error("output column beyond destination width");

    a_done_pos: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg && out_beat_reg.frame_done |->
            (CW'(out_beat_reg.out_col) + CW'(1) == CW'(dst_width_reg)))
        else $error("frame_done off the last output column");

endmodule

// ===== verif/ccnd_checker.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ccnd_checker
// Watches the pixel, result and register ports of the crop/downscale block.
// It keeps its own copy of the geometry registers and the position trackers,
// works out the expected beat for every kept source pixel, and compares
// each returned beat field by field against the oldest expected one.
// ----------------------------------------------------------------------------
module ccnd_checker (
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             in_valid,
    input  logic                             in_ready,
    input  ccnd_pkg::in_beat_t               in_beat,
    input  logic                             out_valid,
    input  logic                             out_ready,
    input  ccnd_pkg::out_beat_t              out_beat,
    input  logic                             cfg_write,
    input  logic [ccnd_pkg::CFG_IDX_W-1:0]   cfg_index,
    input  logic [ccnd_pkg::CFG_DATA_W-1:0]  cfg_data,
    output int                               mismatches,
    output int                               outstanding
);

    localparam int DIM_W   = ccnd_pkg::DIM_W;
    localparam int SCALE_W = ccnd_pkg::SCALE_W;
    localparam int FRAC    = ccnd_pkg::FRAC_BITS;
    localparam int ACC_W   = DIM_W + FRAC;

    logic [DIM_W-1:0]   src_w;
    logic [DIM_W-1:0]   src_h;
    logic [DIM_W-1:0]   dst_w;
    logic [DIM_W-1:0]   dst_h;
    logic [SCALE_W-1:0] step_x;
    logic [SCALE_W-1:0] step_y;
    ccnd_pkg::pix_fmt_t fmt;

    logic [DIM_W-1:0]   src_col;
    logic [DIM_W-1:0]   src_row;
    logic [DIM_W-1:0]   nxt_col;
    logic [DIM_W-1:0]   nxt_row;
    logic [ACC_W-1:0]   col_acc;
    logic [ACC_W-1:0]   row_acc;

    ccnd_pkg::out_beat_t kept_pixels[$];

    assign outstanding = kept_pixels.size();

    always @(posedge clk or negedge rst_n)
    begin : track
        int                  sw;
        int                  sh;
        int                  crop;
        int                  tx;
        int                  ty;
        logic [7:0]          r;
        logic [7:0]          g;
        logic [7:0]          b;
        logic [ACC_W:0]      sum;
        ccnd_pkg::out_beat_t pix;
        ccnd_pkg::out_beat_t want;
        if (!rst_n)
        begin
            src_w   = ccnd_pkg::RST_SRC_WIDTH;
            src_h   = ccnd_pkg::RST_SRC_HEIGHT;
            dst_w   = ccnd_pkg::RST_DST_WIDTH;
            dst_h   = ccnd_pkg::RST_DST_HEIGHT;
            step_x  = ccnd_pkg::RST_SCALE;
            step_y  = ccnd_pkg::RST_SCALE;
            fmt     = ccnd_pkg::FMT_RGB888;
            src_col = '0;
            src_row = '0;
            nxt_col = '0;
            nxt_row = '0;
            col_acc = '0;
            row_acc = '0;
            kept_pixels.delete();
            mismatches = 0;
        end
        else
        begin
            if (out_valid && out_ready)
            begin
                if (kept_pixels.size() == 0)
                begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("%0t: output beat with nothing expected: col %0d row %0d",
                                 $time, out_beat.out_col, out_beat.out_row);
                end
                else
                begin
                    want = kept_pixels.pop_front();
                    if (want.red_q !== out_beat.red_q ||
                        want.green_q !== out_beat.green_q ||
                        want.blue_q !== out_beat.blue_q ||
                        want.display_rgb565 !== out_beat.display_rgb565 ||
                        want.out_col !== out_beat.out_col ||
                        want.out_row !== out_beat.out_row ||
                        want.frame_done !== out_beat.frame_done)
                    begin
                        mismatches++;
                        if (mismatches <= 10)
                        begin
                            $display("%0t: exp r %0d g %0d b %0d disp %04h c %0d r %0d f %0b",
                                     $time, want.red_q, want.green_q, want.blue_q,
                                     want.display_rgb565, want.out_col, want.out_row,
                                     want.frame_done);
                            $display("%0t: got r %0d g %0d b %0d disp %04h c %0d r %0d f %0b",
                                     $time, out_beat.red_q, out_beat.green_q,
                                     out_beat.blue_q, out_beat.display_rgb565,
                                     out_beat.out_col, out_beat.out_row,
                                     out_beat.frame_done);
                        end
                    end
                end
            end

            if (cfg_write)
            begin
                case (ccnd_pkg::cfg_reg_t'(cfg_index))
                    ccnd_pkg::REG_SRC_WIDTH:    src_w  = cfg_data[DIM_W-1:0];
                    ccnd_pkg::REG_SRC_HEIGHT:   src_h  = cfg_data[DIM_W-1:0];
                    ccnd_pkg::REG_DST_WIDTH:    dst_w  = cfg_data[DIM_W-1:0];
                    ccnd_pkg::REG_DST_HEIGHT:   dst_h  = cfg_data[DIM_W-1:0];
                    ccnd_pkg::REG_SCALE_X:      step_x = cfg_data[SCALE_W-1:0];
                    ccnd_pkg::REG_SCALE_Y:      step_y = cfg_data[SCALE_W-1:0];
                    ccnd_pkg::REG_INPUT_FORMAT: fmt    = ccnd_pkg::pix_fmt_t'(cfg_data[0]);
                    default: ;
                endcase
            end

            if (in_valid && in_ready)
            begin
                // zero-sized source behaves as one pixel
                sw   = (src_w == '0) ? 1 : int'(src_w);
                sh   = (src_h == '0) ? 1 : int'(src_h);
                crop = (sw < sh) ? sw : sh;

                if (in_beat.start_of_frame)
                begin
                    src_col = '0;
                    src_row = '0;
                    nxt_col = '0;
                    nxt_row = '0;
                    col_acc = '0;
                    row_acc = '0;
                end

                if (fmt == ccnd_pkg::FMT_RGB565)
                begin
                    r = {in_beat.pixel_word[15:11], 3'b000};
                    g = {in_beat.pixel_word[10:5], 2'b00};
                    b = {in_beat.pixel_word[4:0], 3'b000};
                end
                else
                begin
                    r = in_beat.pixel_word[23:16];
                    g = in_beat.pixel_word[15:8];
                    b = in_beat.pixel_word[7:0];
                end

                tx = (sw - crop) / 2 + int'(col_acc >> FRAC);
                if (tx > sw - 1)
                    tx = sw - 1;
                ty = (sh - crop) / 2 + int'(row_acc >> FRAC);
                if (ty > sh - 1)
                    ty = sh - 1;

                if (nxt_row < dst_h && nxt_col < dst_w &&
                    int'(src_row) >= ty && int'(src_col) >= tx)
                begin
                    pix.red_q          = r ^ ccnd_pkg::QUANT_FLIP;
                    pix.green_q        = g ^ ccnd_pkg::QUANT_FLIP;
                    pix.blue_q         = b ^ ccnd_pkg::QUANT_FLIP;
                    pix.display_rgb565 = {r[7:3], g[7:2], b[7:3]};
                    pix.out_col        = nxt_col;
                    pix.out_row        = nxt_row;
                    pix.frame_done     = (int'(nxt_col) + 1 == int'(dst_w)) &&
                                         (int'(nxt_row) + 1 == int'(dst_h));
                    kept_pixels.push_back(pix);

                    // accumulators saturate at all ones
                    nxt_col = nxt_col + 1'b1;
                    sum     = col_acc + step_x;
                    col_acc = sum[ACC_W] ? '1 : sum[ACC_W-1:0];
                    if (nxt_col >= dst_w)
                    begin
                        nxt_col = '0;
                        col_acc = '0;
                        nxt_row = nxt_row + 1'b1;
                        sum     = row_acc + step_y;
                        row_acc = sum[ACC_W] ? '1 : sum[ACC_W-1:0];
                    end
                end

                src_col = src_col + 1'b1;
                if (int'(src_col) >= sw || src_col == '0)
                begin
                    src_col = '0;
                    if (src_row != '1)
                        src_row = src_row + 1'b1;
                end
            end
        end
    end

endmodule

// ===== verif/tb.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb
// Top of the crop/downscale/quantize testbench. Programs the geometry
// registers between phases, streams source pixel beats with random gaps and
// random result back-pressure, and reports the verdict from the checker.
// Directed phases cover byte extremes, both pixel formats, degenerate sizes,
// fractional and saturating steps; random phases follow with mostly whole
// small frames plus overruns, cut frames, stray frame marks and mid-stream
// register changes.
// ----------------------------------------------------------------------------
module tb;

    localparam int PIX_W = ccnd_pkg::PIX_W;

    logic                            clk = 1'b0;
    logic                            rst_n;
    logic                            in_valid;
    logic                            in_ready;
    ccnd_pkg::in_beat_t              in_beat;
    logic                            out_valid;
    logic                            out_ready;
    ccnd_pkg::out_beat_t             out_beat;
    logic                            cfg_write;
    logic [ccnd_pkg::CFG_IDX_W-1:0]  cfg_index;
    logic [ccnd_pkg::CFG_DATA_W-1:0] cfg_data;

    int                    mismatches;
    int                    outstanding;
    int                    pixels_sent;
    int                    frame_pixels;
    bit                    quiet;
    bit                    calm;

    center_crop_nn_downscale_quant dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .in_beat   (in_beat),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .out_beat  (out_beat),
        .cfg_write (cfg_write),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    ccnd_checker chk (
        .clk         (clk),
        .rst_n       (rst_n),
        .in_valid    (in_valid),
        .in_ready    (in_ready),
        .in_beat     (in_beat),
        .out_valid   (out_valid),
        .out_ready   (out_ready),
        .out_beat    (out_beat),
        .cfg_write   (cfg_write),
        .cfg_index   (cfg_index),
        .cfg_data    (cfg_data),
        .mismatches  (mismatches),
        .outstanding (outstanding)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    function automatic int idle_len();
        if (quiet || calm || $urandom_range(0, 5) != 0)
            return 0;
        return $urandom_range(1, 11);
    endfunction

    task automatic write_reg(input ccnd_pkg::cfg_reg_t idx, input logic [31:0] val);
        @(negedge clk);
        cfg_write <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val[ccnd_pkg::CFG_DATA_W-1:0];
        @(negedge clk);
        cfg_write <= 1'b0;
    endtask

    task automatic set_geometry(input int sw, input int sh, input int dw, input int dh,
                                input int unsigned sx, input int unsigned sy,
                                input ccnd_pkg::pix_fmt_t fmt);
        write_reg(ccnd_pkg::REG_SRC_WIDTH, sw);
        write_reg(ccnd_pkg::REG_SRC_HEIGHT, sh);
        write_reg(ccnd_pkg::REG_DST_WIDTH, dw);
        write_reg(ccnd_pkg::REG_DST_HEIGHT, dh);
        write_reg(ccnd_pkg::REG_SCALE_X, sx);
        write_reg(ccnd_pkg::REG_SCALE_Y, sy);
        write_reg(ccnd_pkg::REG_INPUT_FORMAT, fmt);
        frame_pixels = (sw < 1 ? 1 : sw) * (sh < 1 ? 1 : sh);
    endtask

    task automatic send_pixel(input logic sof, input logic [PIX_W-1:0] word);
        int gap;
        begin
            gap = idle_len();
            @(negedge clk);
            if (gap > 0)
            begin
                in_valid <= 1'b0;
                repeat (gap) @(negedge clk);
            end
            in_valid <= 1'b1;
            in_beat  <= '{start_of_frame: sof, pixel_word: word};
            @(posedge clk);
            while (!in_ready)
                @(posedge clk);
            pixels_sent++;
            quiet = (pixels_sent >= 1450);
        end
    endtask

    task automatic send_frame(input int count, input bit with_sof, input bit stray_sof);
        for (int i = 0; i < count; i++)
            send_pixel((with_sof && i == 0) || (stray_sof && $urandom_range(0, 31) == 0),
                       PIX_W'($urandom));
    endtask

    // let the block drain before touching registers
    task automatic settle();
        @(negedge clk);
        in_valid <= 1'b0;
        while (outstanding != 0)
            @(negedge clk);
        repeat (8) @(negedge clk);
    endtask

    initial
    begin
        int gap;
        out_ready = 1'b0;
        @(posedge rst_n);
        forever
        begin
            @(negedge clk);
            gap = idle_len();
            if (gap == 0)
                out_ready <= 1'b1;
            else
            begin
                out_ready <= 1'b0;
                repeat (gap) @(negedge clk);
                out_ready <= 1'b1;
            end
        end
    end

    initial
    begin
        #5_000_000;
        $display("== FAIL ==");
        $finish;
    end

    initial
    begin
        int          sw;
        int          sh;
        int          dw;
        int          dh;
        int          crop;
        int          kind;
        int          frames;
        int          cnt;
        int unsigned sx;
        int unsigned sy;
        rst_n       = 1'b0;
        in_valid    = 1'b0;
        in_beat     = '0;
        cfg_write   = 1'b0;
        cfg_index   = '0;
        cfg_data    = '0;
        quiet       = 1'b0;
        calm        = 1'b0;
        pixels_sent = 0;
        repeat (8) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        // byte extremes, then beats past the frame end
        set_geometry(2, 2, 2, 2, 1 << 16, 1 << 16, ccnd_pkg::FMT_RGB888);
        send_pixel(1'b1, 24'h000000);
        send_pixel(1'b0, 24'hFFFFFF);
        send_pixel(1'b0, 24'h807F01);
        send_pixel(1'b0, 24'h7F80FE);
        send_pixel(1'b0, 24'h123456);
        settle();

        // RGB565: upper byte ignored
        write_reg(ccnd_pkg::REG_INPUT_FORMAT, ccnd_pkg::FMT_RGB565);
        send_pixel(1'b1, 24'hFFFFFF);
        send_pixel(1'b0, 24'hFF0000);
        send_pixel(1'b0, 24'h00F81F);
        settle();

        // zero source size acts as 1x1
        set_geometry(0, 0, 1, 1, 1 << 16, 1 << 16, ccnd_pkg::FMT_RGB888);
        send_pixel(1'b1, 24'hA5C3E7);
        send_pixel(1'b0, 24'h5A3C18);
        send_pixel(1'b1, 24'h0F0F0F);
        settle();

        // zero destination: nothing comes out
        set_geometry(2, 2, 0, 0, 1 << 16, 1 << 16, ccnd_pkg::FMT_RGB888);
        send_frame(4, 1'b1, 1'b0);
        settle();

        // step below one, destination larger than the crop
        set_geometry(3, 2, 3, 3, 1 << 15, 1 << 15, ccnd_pkg::FMT_RGB565);
        send_frame(6, 1'b1, 1'b0);
        settle();

        // step 1023.0 in Q16: accumulators saturate
        set_geometry(3, 3, 3, 3, 67043328, 67043328, ccnd_pkg::FMT_RGB888);
        send_frame(9, 1'b1, 1'b0);
        settle();

        // largest sizes, head of the frame only
        set_geometry(1023, 1023, 1023, 1023, 1 << 16, 1 << 16, ccnd_pkg::FMT_RGB565);
        send_frame(40, 1'b1, 1'b0);
        settle();

        while (pixels_sent < 1700)
        begin
            kind = $urandom_range(0, 9);
            calm = ($urandom_range(0, 3) == 0);
            sw   = $urandom_range(1, 12);
            sh   = $urandom_range(1, 12);
            if (kind == 0)
            begin
                sw = $urandom_range(0, 1023);
                sh = $urandom_range(0, 1023);
            end
            crop = (sw < 1 ? 1 : sw) < (sh < 1 ? 1 : sh) ? (sw < 1 ? 1 : sw) : (sh < 1 ? 1 : sh);
            dw   = $urandom_range(1, crop);
            dh   = $urandom_range(1, crop);
            sx   = (crop << 16) / dw;
            sy   = (crop << 16) / dh;
            if (kind == 1)
            begin
                dw = $urandom_range(0, 16);
                dh = $urandom_range(0, 16);
                sx = $urandom_range(0, 1) ? $urandom_range(0, 1 << 17)
                                          : $urandom_range(0, 67043328);
                sy = $urandom_range(0, 1) ? $urandom_range(0, 1 << 17)
                                          : $urandom_range(0, 67043328);
            end
            set_geometry(sw, sh, dw, dh, sx, sy,
                         ccnd_pkg::pix_fmt_t'($urandom_range(0, 1)));
            frames = $urandom_range(1, 3);
            for (int f = 0; f < frames; f++)
            begin
                cnt = frame_pixels;
                if (kind == 0)
                    cnt = $urandom_range(1, 60);
                else if (kind == 3)
                    cnt = cnt + $urandom_range(1, 6);
                else if (kind == 4)
                    cnt = $urandom_range(1, cnt);
                // kind 5 keeps the previous stream position under new registers
                send_frame(cnt, !(kind == 5 && f == 0), kind == 6);
            end
            settle();
        end

        if (mismatches == 0 && outstanding == 0)
            $display("== PASS ==");
        else
            $display("== FAIL ==");
        $finish;
    end

endmodule

// ===== sim.f =====
rtl/ccnd_pkg.sv
rtl/ccnd_pixel_fmt.sv
rtl/center_crop_nn_downscale_quant.sv
verif/ccnd_checker.sv
verif/tb.sv
